/* rtl/tt800_pkg.sv */
// Shared types, constants and word functions of the TT800 word generator.
// Used by tt800_random_word_generator_top; depends on nothing.
package tt800_pkg;

  localparam int STATE_WORDS = 25;
  localparam int TAP_OFFSET  = 7;
  localparam int WORD_W      = 32;
  localparam int IDX_W       = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam word_t TWIST_VECTOR = 32'h8ebf_d028;
  localparam word_t TEMPER_B     = 32'h2b5b_2500;
  localparam word_t TEMPER_C     = 32'hdb8b_0000;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_GEN  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_TWIST,
    ST_TWIST_LAST
  } fsm_t;

  function automatic idx_t tap_index(input idx_t idx);
    logic [IDX_W:0] sum;
    sum = {1'b0, idx} + (IDX_W + 1)'(TAP_OFFSET);
    if (sum >= (IDX_W + 1)'(STATE_WORDS)) begin
      sum = sum - (IDX_W + 1)'(STATE_WORDS);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic word_t twist(input word_t cur, input word_t tap);
    word_t v;
    v = tap ^ (cur >> 1);
    if (cur[0]) begin
      v = v ^ TWIST_VECTOR;
    end
    return v;
  endfunction

  function automatic word_t temper(input word_t y_in);
    word_t y;
    y = y_in;
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 16);
    return y;
  endfunction

endpackage

/* rtl/tt800_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; instantiated twice by the generator top level.
module tt800_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 25,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tt800_random_word_generator_top.sv */
// Top level of the TT800 twisted GFSR word generator: control, two RAM copies.
// Depends on tt800_pkg and tt800_ram.
//
//   channel  signals                         direction  meaning
//   in       in_valid/in_ready, cmd,          input      load a seed word or request a word
//            seed_index, seed_value
//   out      out_valid/out_ready, random_word output     one tempered word per request
//
// A request reads the state RAM, then tempers the word into the output register.
// From the 26th request on, every 25th request first regenerates the store, one word
// per cycle through the two RAM copies. Reset clears the valid bits at once, so the
// store reads as zeros. A waiting result does not block the next input transfer; a
// second result waits in the read step until the output register is free.
module tt800_random_word_generator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  tt800_pkg::idx_t    seed_index,
  input  tt800_pkg::word_t   seed_value,
  output logic               out_valid,
  input  logic               out_ready,
  output tt800_pkg::word_t   random_word
);

  import tt800_pkg::*;

  fsm_t                   state;
  fsm_t                   state_next;
  idx_t                   pos;
  idx_t                   cnt;
  idx_t                   wr_idx;
  logic                   wr_pending;
  logic [STATE_WORDS-1:0] valid_bits;
  logic                   rd_ok_a;
  logic                   rd_ok_b;
  idx_t                   rd_addr_a;
  idx_t                   rd_addr_b;
  logic                   ram_we;
  idx_t                   ram_waddr;
  word_t                  ram_wdata;
  word_t                  q_a;
  word_t                  q_b;
  word_t                  word_a;
  word_t                  word_b;
  word_t                  twisted;
  logic                   pos_at_end;
  logic                   out_load;

  tt800_ram #(.WIDTH(WORD_W), .DEPTH(STATE_WORDS)) u_ram_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr_a),
    .rdata (q_a)
  );

  tt800_ram #(.WIDTH(WORD_W), .DEPTH(STATE_WORDS)) u_ram_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr_b),
    .rdata (q_b)
  );

  assign word_a     = rd_ok_a ? q_a : '0;
  assign word_b     = rd_ok_b ? q_b : '0;
  assign twisted    = twist(word_a, word_b);
  assign pos_at_end = (pos >= IDX_W'(STATE_WORDS));
  assign out_load   = (state == ST_READ) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && (cmd == CMD_GEN)) begin
          state_next = pos_at_end ? ST_TWIST : ST_READ;
        end
      end
      ST_READ: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      ST_TWIST: begin
        if (cnt == IDX_W'(STATE_WORDS - 1)) begin
          state_next = ST_TWIST_LAST;
        end
      end
      ST_TWIST_LAST: begin
        state_next = ST_READ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    rd_addr_a = '0;
    rd_addr_b = '0;
    ram_we    = 1'b0;
    ram_waddr = wr_idx;
    ram_wdata = twisted;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        rd_addr_a = pos_at_end ? '0 : pos;
        ram_we    = in_valid && (cmd == CMD_LOAD) && (seed_index < IDX_W'(STATE_WORDS));
        ram_waddr = seed_index;
        ram_wdata = seed_value;
      end
      ST_READ: begin
        rd_addr_a = pos;
      end
      ST_TWIST: begin
        rd_addr_a = cnt;
        rd_addr_b = tap_index(cnt);
        ram_we    = wr_pending;
      end
      ST_TWIST_LAST: begin
        ram_we = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos        <= '0;
      cnt        <= '0;
      wr_pending <= 1'b0;
      valid_bits <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      wr_pending <= (state == ST_TWIST);
      if (ram_we) begin
        valid_bits[ram_waddr] <= 1'b1;
      end
      if (state == ST_TWIST) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (state == ST_TWIST_LAST) begin
        pos <= '0;
      end else if (out_load) begin
        pos <= pos + 1'b1;
      end
      out_valid <= out_load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_a <= valid_bits[rd_addr_a];
    rd_ok_b <= valid_bits[rd_addr_b];
    wr_idx  <= cnt;
    if (out_load) begin
      random_word <= temper(word_a);
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= IDX_W'(STATE_WORDS))
    else $error("Read position passed the end of the store.");

  a_twist_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TWIST && wr_pending) |->
      (wr_idx != cnt && wr_idx != tap_index(cnt)))
    else $error("Twist write hits an address being read.");

  a_twist_fills: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TWIST_LAST) |=> ((&valid_bits) && pos == '0 && state == ST_READ))
    else $error("Regeneration did not rewrite the whole store.");

  a_out_from_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> ($past(state) == ST_READ))
    else $error("Result appeared without a read step.");

endmodule
